[sv/sfir_pkg.sv]
package sfir_pkg;

    // Item and register widths
    localparam int SAMPLE_W      = 32;
    localparam int WEIGHT_W      = 16;
    localparam int OUT_W         = 22;
    localparam int FRAC_SH       = 30;
    localparam int PROD_W        = SAMPLE_W + WEIGHT_W;
    localparam int TERM_W        = PROD_W - FRAC_SH;

    // Configuration port
    localparam int WEIGHT_REGS   = 8;
    localparam int WIDX_W        = $clog2(WEIGHT_REGS);
    localparam int CFG_ADDR_W    = WIDX_W + 2;
    localparam int CFG_DATA_W    = 32;

    // Default filter length
    localparam int TAP_COUNT_DEF = 15;

    // Centre tap register, also used for any tap beyond it on longer filters
    localparam logic [WIDX_W-1:0] W_IDX_CENTRE = WIDX_W'(WEIGHT_REGS - 1);

    // Reset weights, Q0.16, outermost pair first, centre last
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [WEIGHT_REGS] = '{
        16'd47, 16'd221, 16'd544, 16'd1013, 16'd1566, 16'd2096, 16'd2481, 16'd2621
    };

    // One tap presented to the multiply-accumulate unit
    typedef struct packed {
        logic                vld;
        logic                first;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0] weight;
    } tap_t;

    // Finished sum from the multiply-accumulate unit
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] sum;
    } mac_res_t;

endpackage

[sv/sfir_ram.sv]
module sfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/sfir_mac.sv]
module sfir_mac
    import sfir_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  tap_t     tap,
    output mac_res_t res
);

    localparam int RAW_W = TERM_W + $clog2(TAP_COUNT);
    localparam int ACC_W = (RAW_W > OUT_W) ? RAW_W : OUT_W + 1;

    logic [PROD_W-1:0] prod_reg;
    logic              prod_vld_reg;
    logic              prod_first_reg;
    logic              prod_last_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic              done_reg;
    logic [ACC_W-1:0]  term;

    // Drop the fraction bits of each product before it is summed
    assign term = ACC_W'(prod_reg[PROD_W-1:FRAC_SH]);

    always_comb begin
        if (prod_first_reg) begin
            acc_next = term;
        end else begin
            acc_next = acc_reg + term;
        end
    end

    // Multiply stage, then accumulate stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg   <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            prod_vld_reg   <= tap.vld;
            prod_first_reg <= tap.first;
            prod_last_reg  <= tap.last;
            done_reg       <= prod_vld_reg && prod_last_reg;
        end
        prod_reg <= PROD_W'(tap.sample) * PROD_W'(tap.weight);
        if (prod_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Saturate the sum to the output width
    assign res.done = done_reg;
    assign res.sum  = (|acc_reg[ACC_W-1:OUT_W]) ? '1 : acc_reg[OUT_W-1:0];

endmodule

[sv/symmetric_fir_filter.sv]
// Channel   Direction  Ports                                   Handshake
// s_        in         s_mic_sample [31:0]                     s_valid / s_ready
// m_        out        m_filtered_value [21:0]                 m_valid / m_ready
// apb       in/out     paddr [4:0], pwdata, prdata [31:0]      psel, penable, pwrite, pready
//
// Each item passes these steps in order: accept the item and write the sample into the
// delay-line RAM, one RAM read per tap through the single read port, the multiply and
// accumulate stages, seeing the finished sum, and handing it to the output register.
// Reset is synchronous, active low; it restores the weights and marks every delay-line
// entry as zero through per-entry valid bits, so no clearing pass is needed.
// A finished result waits in the output register; s_ready returns as soon as the sum
// has moved there, and a stalled m_ready holds the block only when a second sum is ready.
module symmetric_fir_filter
    import sfir_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_mic_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_filtered_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_W = $clog2(TAP_COUNT);
    localparam int MW_W   = SLOT_W + WIDX_W;

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        DRAIN,
        FINISH
    } state_t;

    state_t              state_reg;
    logic [SLOT_W-1:0]   wr_slot_reg;
    logic [SLOT_W-1:0]   rd_slot_reg;
    logic [SLOT_W-1:0]   tap_cnt_reg;
    logic [TAP_COUNT-1:0] valid_reg;
    logic                tap_vld_reg;
    logic                tap_first_reg;
    logic                tap_last_reg;
    logic                tap_mask_reg;
    logic [WEIGHT_W-1:0] tap_weight_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;
    logic [WEIGHT_W-1:0] weight_reg [WEIGHT_REGS];

    logic                in_fire;
    logic                out_free;
    logic                cfg_write;
    logic [WIDX_W-1:0]   cfg_idx;
    logic [SLOT_W-1:0]   mirror;
    logic [SLOT_W-1:0]   m_raw;
    logic [MW_W-1:0]     m_wide;
    logic [WIDX_W-1:0]   w_idx;
    logic [SLOT_W-1:0]   rd_slot_dec;
    logic [SLOT_W-1:0]   wr_slot_inc;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;
    tap_t                tap;
    mac_res_t            mac_res;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;
    assign m_filtered_value = m_data_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = CFG_DATA_W'(weight_reg[cfg_idx]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
        end else if (cfg_write) begin
            weight_reg[cfg_idx] <= pwdata[WEIGHT_W-1:0];
        end
    end

    // Mirror the tap index onto its weight register, clamp to the centre
    always_comb begin
        mirror = SLOT_W'(TAP_COUNT - 1) - tap_cnt_reg;
        m_raw  = (tap_cnt_reg < mirror) ? tap_cnt_reg : mirror;
        m_wide = MW_W'(m_raw);
        w_idx  = (m_wide > MW_W'(W_IDX_CENTRE)) ? W_IDX_CENTRE : m_wide[WIDX_W-1:0];
    end

    // Step the circular slots
    assign rd_slot_dec = (rd_slot_reg == '0) ? SLOT_W'(TAP_COUNT - 1) : rd_slot_reg - 1'b1;
    assign wr_slot_inc = (wr_slot_reg == SLOT_W'(TAP_COUNT - 1)) ? '0 : wr_slot_reg + 1'b1;

    // Delay line: written only in IDLE and read only in RUN, so accesses never overlap
    assign ram_re = (state_reg == RUN);

    sfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAP_COUNT)
    ) u_delay_ram (
        .clk   (aclk),
        .we    (in_fire),
        .waddr (wr_slot_reg),
        .wdata (s_mic_sample),
        .re    (ram_re),
        .raddr (rd_slot_reg),
        .rdata (ram_rdata)
    );

    // Present each read sample with its weight; an entry never written reads as zero
    always_comb begin
        tap.vld    = tap_vld_reg;
        tap.first  = tap_first_reg;
        tap.last   = tap_last_reg;
        tap.sample = ram_rdata & {SAMPLE_W{tap_mask_reg}};
        tap.weight = tap_weight_reg;
    end

    sfir_mac #(
        .TAP_COUNT (TAP_COUNT)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tap     (tap),
        .res     (mac_res)
    );

    // Sequencer: write the sample, walk the taps newest first, drain, hand over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            tap_cnt_reg   <= '0;
            valid_reg     <= '0;
            tap_vld_reg   <= 1'b0;
            tap_first_reg <= 1'b0;
            tap_last_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            tap_vld_reg   <= (state_reg == RUN);
            tap_first_reg <= (state_reg == RUN) && (tap_cnt_reg == '0);
            tap_last_reg  <= (state_reg == RUN) && (tap_cnt_reg == SLOT_W'(TAP_COUNT - 1));
            if ((state_reg == FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (in_fire) begin
                        valid_reg[wr_slot_reg] <= 1'b1;
                        rd_slot_reg <= wr_slot_reg;
                        wr_slot_reg <= wr_slot_inc;
                        tap_cnt_reg <= '0;
                        state_reg   <= RUN;
                    end
                end
                RUN: begin
                    rd_slot_reg   <= rd_slot_dec;
                    if (tap_cnt_reg == SLOT_W'(TAP_COUNT - 1)) begin
                        state_reg <= DRAIN;
                    end else begin
                        tap_cnt_reg <= tap_cnt_reg + 1'b1;
                    end
                end
                DRAIN: begin
                    if (mac_res.done) begin
                        state_reg <= FINISH;
                    end
                end
                FINISH: begin
                    if (out_free) begin
                        m_data_reg  <= mac_res.sum;
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
        if (state_reg == RUN) begin
            tap_weight_reg <= weight_reg[w_idx];
            tap_mask_reg   <= valid_reg[rd_slot_reg];
        end
    end

    // An accepted item always starts the tap walk
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == RUN))
        else $error("accepted item did not start the tap walk");

    // The tap counter never runs past the last tap
    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RUN) |-> (tap_cnt_reg <= SLOT_W'(TAP_COUNT - 1)))
        else $error("tap counter beyond the last tap");

    // A finished sum only appears while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.done |-> (state_reg == DRAIN))
        else $error("sum finished outside the drain phase");

    // A result is loaded only from the hand-over phase
    a_load_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == FINISH))
        else $error("result loaded outside the hand-over phase");

endmodule
